// ===== design/plt_pkg.sv =====
`default_nettype none
package plt_pkg;

  localparam int NUM_TABLES_DEF = 16;
  localparam int MAX_POINTS_DEF = 32;

  localparam int TNUM_W  = 5;
  localparam int PIDX_W  = 5;
  localparam int PCNT_W  = 6;
  localparam int DATA_W  = 32;

  localparam logic [1:0] CMD_WRITE   = 2'd0;
  localparam logic [1:0] CMD_COUNT   = 2'd1;
  localparam logic [1:0] CMD_CONVERT = 2'd2;

  localparam logic [1:0] PATH_PASS   = 2'd0;
  localparam logic [1:0] PATH_EXACT  = 2'd1;
  localparam logic [1:0] PATH_INTERP = 2'd2;

  typedef enum logic [1:0] {
    REQ_WRITE   = 2'd0,
    REQ_COUNT   = 2'd1,
    REQ_CONVERT = 2'd2
  } req_kind_t;

  // for a convert, raw carries the sample
  typedef struct packed {
    req_kind_t           kind;
    logic                tvalid;
    logic [TNUM_W-1:0]   tbl;
    logic [PIDX_W-1:0]   pidx;
    logic [PCNT_W-1:0]   pcnt;
    logic [DATA_W-1:0]   raw;
    logic [DATA_W-1:0]   scaled;
  } req_t;

  typedef struct packed {
    logic valid;
    req_t req;
  } req_if_t;

endpackage
`default_nettype wire

// ===== design/plt_front.sv =====
`default_nettype none
module plt_front #(
  parameter int NUM_TABLES = 16,
  parameter int MAX_POINTS = 32
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic [1:0]                    command,
  input  wire logic [plt_pkg::TNUM_W-1:0]    table_number,
  input  wire logic [plt_pkg::PIDX_W-1:0]    point_index,
  input  wire logic [plt_pkg::PCNT_W-1:0]    point_count,
  input  wire logic [plt_pkg::DATA_W-1:0]    point_raw,
  input  wire logic [plt_pkg::DATA_W-1:0]    point_scaled,
  input  wire logic [plt_pkg::DATA_W-1:0]    sample,
  output plt_pkg::req_if_t                   req_out,
  input  wire logic                          pop
);
  import plt_pkg::*;

  req_t       q [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  req_t       cls;
  logic       keep;
  logic       push;
  logic       tvalid;

  always_comb begin
    tvalid = (table_number != '0) && (32'(table_number) <= NUM_TABLES);
    cls.tvalid = tvalid;
    cls.tbl    = table_number - TNUM_W'(1);
    cls.pidx   = point_index;
    cls.pcnt   = (32'(point_count) > MAX_POINTS) ? PCNT_W'(MAX_POINTS) : point_count;
    cls.raw    = point_raw;
    cls.scaled = point_scaled;
    cls.kind   = REQ_CONVERT;
    keep       = 1'b0;
    unique case (command)
      CMD_WRITE: begin
        cls.kind = REQ_WRITE;
        keep     = tvalid && (32'(point_index) < MAX_POINTS);
      end
      CMD_COUNT: begin
        cls.kind = REQ_COUNT;
        keep     = tvalid;
      end
      CMD_CONVERT: begin
        cls.kind = REQ_CONVERT;
        cls.raw  = sample;
        keep     = 1'b1;
      end
      default: keep = 1'b0;
    endcase
  end

  assign busy = (count == 2'd2);
  assign push = start && !busy && keep;

  always_ff @(posedge clk) begin
    if (push) begin
      q[wr_ptr] <= cls;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      count <= count + 2'(push) - 2'(pop);
    end
  end

  assign req_out.valid = (count != 2'd0);
  assign req_out.req   = q[rd_ptr];

endmodule
`default_nettype wire

// ===== design/plt_div.sv =====
`default_nettype none
module plt_div (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        go,
  input  wire logic [63:0] dividend,
  input  wire logic [31:0] divisor,
  output logic             done,
  output logic [31:0]      quotient
);
  import plt_pkg::*;

  logic [31:0] rem;
  logic [31:0] lo;
  logic [31:0] dvs;
  logic [5:0]  steps;
  logic        run;
  logic [32:0] rem_sh;
  logic        qbit;

  // high half is below the divisor, so the quotient fits in 32 bits
  always_comb begin
    rem_sh = {rem, lo[31]};
    qbit   = (rem_sh >= {1'b0, dvs});
  end

  always_ff @(posedge clk) begin
    if (go) begin
      rem <= dividend[63:32];
      lo  <= dividend[31:0];
      dvs <= divisor;
    end else if (run) begin
      rem <= qbit ? 32'(rem_sh - {1'b0, dvs}) : rem_sh[31:0];
      lo  <= {lo[30:0], qbit};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run   <= 1'b0;
      steps <= '0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      if (go) begin
        run   <= 1'b1;
        steps <= 6'd32;
      end else if (run) begin
        steps <= steps - 6'd1;
        if (steps == 6'd1) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quotient = lo;

endmodule
`default_nettype wire

// ===== design/plt_back.sv =====
`default_nettype none
module plt_back #(
  parameter int NUM_TABLES = 16,
  parameter int MAX_POINTS = 32
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  plt_pkg::req_if_t                req_in,
  output logic                            pop,
  output logic                            strobe,
  output logic [plt_pkg::DATA_W-1:0]      converted,
  output logic [1:0]                      path
);
  import plt_pkg::*;

  localparam int DEPTH = NUM_TABLES * MAX_POINTS;
  localparam int AW    = $clog2(DEPTH);
  localparam int TW    = (NUM_TABLES > 1) ? $clog2(NUM_TABLES) : 1;
  localparam int IW    = $clog2(MAX_POINTS);
  localparam int CW    = $clog2(MAX_POINTS + 1);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_LOAD  = 6'b000010,
    S_WAIT  = 6'b000100,
    S_MUL   = 6'b001000,
    S_DGO   = 6'b010000,
    S_DIV   = 6'b100000
  } state_t;

  state_t state;
  req_t   rq;

  logic [DATA_W-1:0] raw_mem [DEPTH];
  logic [DATA_W-1:0] scl_mem [DEPTH];
  logic [CW-1:0]     cnt_store [NUM_TABLES];

  logic signed [DATA_W-1:0] rd_raw;
  logic signed [DATA_W-1:0] rd_scl;
  logic signed [DATA_W-1:0] x;
  logic signed [DATA_W-1:0] left_raw;
  logic signed [DATA_W-1:0] left_scl;
  logic signed [DATA_W-1:0] seg_scl;
  logic [TW-1:0]            tsel;
  logic [IW-1:0]            idx;
  logic [CW-1:0]            n;
  logic [AW-1:0]            wa;
  logic [AW-1:0]            ra;
  logic                     mem_we;

  logic [31:0] mag;
  logic [31:0] off;
  logic [31:0] dx;
  logic        neg;
  logic [63:0] prod;
  logic        div_done;
  logic [31:0] quo;

  logic signed [32:0] dy;
  logic [CW-1:0]      tcnt;

  assign rq     = req_in.req;
  assign pop    = req_in.valid && (state == S_IDLE);
  assign mem_we = pop && (rq.kind == REQ_WRITE);
  assign wa     = AW'(int'(rq.tbl[TW-1:0]) * MAX_POINTS + int'(rq.pidx[IW-1:0]));
  assign ra     = AW'(int'(tsel) * MAX_POINTS + int'(idx));
  assign tcnt   = cnt_store[rq.tbl[TW-1:0]];
  assign dy     = 33'(rd_scl) - 33'(left_scl);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      raw_mem[wa] <= rq.raw;
      scl_mem[wa] <= rq.scaled;
    end
    if (state == S_LOAD) begin
      rd_raw <= raw_mem[ra];
      rd_scl <= scl_mem[ra];
    end
  end

  plt_div u_div (
    .clk      (clk),
    .rst      (rst),
    .go       (state == S_DGO),
    .dividend (prod),
    .divisor  (dx),
    .done     (div_done),
    .quotient (quo)
  );

  // datapath registers
  always_ff @(posedge clk) begin
    if (pop && rq.kind == REQ_CONVERT) begin
      x    <= rq.raw;
      tsel <= rq.tbl[TW-1:0];
      n    <= tcnt;
    end
    if (state == S_WAIT) begin
      left_raw <= rd_raw;
      left_scl <= rd_scl;
      seg_scl  <= left_scl;
      dx       <= 32'(rd_raw - left_raw);
      off      <= 32'(x - left_raw);
      neg      <= dy[32];
      mag      <= dy[32] ? 32'(-dy) : 32'(dy);
    end
    if (state == S_MUL) begin
      prod <= 64'(mag) * 64'(off);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      strobe <= 1'b0;
      idx    <= '0;
      for (int i = 0; i < NUM_TABLES; i++) begin
        cnt_store[i] <= '0;
      end
    end else begin
      strobe <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (pop) begin
            case (rq.kind)
              REQ_COUNT: cnt_store[rq.tbl[TW-1:0]] <= CW'(rq.pcnt);
              REQ_CONVERT: begin
                if (!rq.tvalid || tcnt < CW'(2)) begin
                  strobe    <= 1'b1;
                  converted <= rq.raw;
                  path      <= PATH_PASS;
                end else begin
                  idx   <= '0;
                  state <= S_LOAD;
                end
              end
              default: ;
            endcase
          end
        end
        S_LOAD: state <= S_WAIT;
        S_WAIT: begin
          if (idx == '0) begin
            idx   <= IW'(1);
            state <= S_LOAD;
          end else if (left_raw == x) begin
            strobe    <= 1'b1;
            converted <= left_scl;
            path      <= PATH_EXACT;
            state     <= S_IDLE;
          end else if (rd_raw == x) begin
            strobe    <= 1'b1;
            converted <= rd_scl;
            path      <= PATH_EXACT;
            state     <= S_IDLE;
          end else if (left_raw < x && x < rd_raw) begin
            state <= S_MUL;
          end else if (CW'(idx) + CW'(1) == n) begin
            strobe    <= 1'b1;
            converted <= x;
            path      <= PATH_PASS;
            state     <= S_IDLE;
          end else begin
            idx   <= idx + IW'(1);
            state <= S_LOAD;
          end
        end
        S_MUL: state <= S_DGO;
        S_DGO: state <= S_DIV;
        S_DIV: begin
          if (div_done) begin
            strobe    <= 1'b1;
            // seg_scl holds the segment's left scaled value
            converted <= neg ? 32'(seg_scl - $signed(quo)) : 32'(seg_scl + $signed(quo));
            path      <= PATH_INTERP;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_interp_after_div: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV && div_done) |=> (strobe && path == PATH_INTERP))
    else $error("interpolated result missing after division");

  a_pop_idle: assert property (@(posedge clk) disable iff (rst)
    pop |-> (state == S_IDLE))
    else $error("request taken while busy");

  a_no_strobe_mid_scan: assert property (@(posedge clk) disable iff (rst)
    (state == S_MUL || state == S_DGO) |-> !strobe)
    else $error("result during multiply");

endmodule
`default_nettype wire

// ===== design/piecewise_linear_table_convert_core.sv =====
`default_nettype none
// Channel   Handshake          Fields
// request   start / busy       command table_number point_index point_count
//                              point_raw point_scaled sample
// result    strobe (1 cycle)   converted path
//
// Write and count requests complete as the back end takes them. A convert reads the
// breakpoints in turn (one-port table memory, registered read: S_LOAD then S_WAIT)
// and, when it interpolates, then runs a multiply and a bit-serial divide. A two-entry
// request queue lets the front keep taking requests; busy is high while it is full.
// Synchronous reset clears point counts and control; breakpoint memories are not
// cleared. Results cannot be stalled.
module piecewise_linear_table_convert_core #(
  parameter int NUM_TABLES = plt_pkg::NUM_TABLES_DEF,
  parameter int MAX_POINTS = plt_pkg::MAX_POINTS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic [1:0]                    command,
  input  wire logic [plt_pkg::TNUM_W-1:0]    table_number,
  input  wire logic [plt_pkg::PIDX_W-1:0]    point_index,
  input  wire logic [plt_pkg::PCNT_W-1:0]    point_count,
  input  wire logic [plt_pkg::DATA_W-1:0]    point_raw,
  input  wire logic [plt_pkg::DATA_W-1:0]    point_scaled,
  input  wire logic [plt_pkg::DATA_W-1:0]    sample,
  output logic                               strobe,
  output logic [plt_pkg::DATA_W-1:0]         converted,
  output logic [1:0]                         path
);
  import plt_pkg::*;

  req_if_t req;
  logic    pop;

  plt_front #(
    .NUM_TABLES (NUM_TABLES),
    .MAX_POINTS (MAX_POINTS)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .command      (command),
    .table_number (table_number),
    .point_index  (point_index),
    .point_count  (point_count),
    .point_raw    (point_raw),
    .point_scaled (point_scaled),
    .sample       (sample),
    .req_out      (req),
    .pop          (pop)
  );

  plt_back #(
    .NUM_TABLES (NUM_TABLES),
    .MAX_POINTS (MAX_POINTS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .req_in    (req),
    .pop       (pop),
    .strobe    (strobe),
    .converted (converted),
    .path      (path)
  );

endmodule
`default_nettype wire

// ===== verif/tb.sv =====
`timescale 1ns / 1ps
module tb;
  import plt_pkg::*;

  localparam int NTAB = NUM_TABLES_DEF;
  localparam int NPTS = MAX_POINTS_DEF;
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  class conversion_scoreboard;
    logic [31:0] raw_mem [NTAB][NPTS];
    logic [31:0] scaled_mem [NTAB][NPTS];
    bit written [NTAB][NPTS];
    logic [5:0] point_total [NTAB];
    logic [31:0] pending_value [$];
    logic [1:0] pending_path [$];
    int errors;

    function new();
      foreach (point_total[i]) point_total[i] = '0;
      foreach (written[i, j]) written[i][j] = 1'b0;
      errors = 0;
    endfunction

    // index of the first entry a convert would read before it is written, or -1
    function int first_gap(int t);
      for (int i = 0; i < point_total[t]; i++)
        if (!written[t][i]) return i;
      return -1;
    endfunction

    function logic [33:0] convert_value(int t, logic [31:0] smp);
      longint x, xl, yl, xr, yr, dy;
      bit [63:0] dx, off, mag, q;
      x = longint'($signed(smp));
      for (int i = 0; i + 1 < point_total[t]; i++) begin
        xl = longint'($signed(raw_mem[t][i]));
        yl = longint'($signed(scaled_mem[t][i]));
        xr = longint'($signed(raw_mem[t][i+1]));
        yr = longint'($signed(scaled_mem[t][i+1]));
        if (xl == x) return {PATH_EXACT, yl[31:0]};
        if (xr == x) return {PATH_EXACT, yr[31:0]};
        if (xl < x && x < xr) begin
          dx = xr - xl;
          off = x - xl;
          dy = yr - yl;
          mag = dy < 0 ? -dy : dy;
          q = (mag * off) / dx;
          if (dy < 0) return {PATH_INTERP, 32'(yl - longint'(q))};
          return {PATH_INTERP, 32'(yl + longint'(q))};
        end
      end
      return {PATH_PASS, smp};
    endfunction

    function void note(logic [1:0] cmd, logic [4:0] tn, logic [4:0] pi, logic [5:0] pc,
                       logic [31:0] praw, logic [31:0] pscl, logic [31:0] smp);
      bit tv;
      int t;
      logic [33:0] r;
      tv = tn >= 1 && tn <= NTAB;
      t = tv ? tn - 1 : 0;
      case (cmd)
        CMD_WRITE: if (tv && pi < NPTS) begin
          raw_mem[t][pi] = praw;
          scaled_mem[t][pi] = pscl;
          written[t][pi] = 1'b1;
        end
        CMD_COUNT: if (tv) point_total[t] = pc > NPTS ? 6'(NPTS) : pc;
        CMD_CONVERT: begin
          r = tv ? convert_value(t, smp) : {PATH_PASS, smp};
          pending_value.push_back(r[31:0]);
          pending_path.push_back(r[33:32]);
        end
        default: ;
      endcase
    endfunction

    function void check(logic [31:0] v, logic [1:0] p);
      logic [31:0] ev;
      logic [1:0] ep;
      if (pending_value.size() == 0) begin
        $error("result with nothing expected: converted %h path %0d", v, p);
        errors++;
        return;
      end
      ev = pending_value.pop_front();
      ep = pending_path.pop_front();
      if (v !== ev) begin
        $error("converted expected %h actual %h", ev, v);
        errors++;
      end
      if (p !== ep) begin
        $error("path expected %0d actual %0d", ep, p);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic [1:0] command = '0;
  logic [4:0] table_number = '0;
  logic [4:0] point_index = '0;
  logic [5:0] point_count = '0;
  logic [31:0] point_raw = '0;
  logic [31:0] point_scaled = '0;
  logic [31:0] sample = '0;
  logic busy, strobe;
  logic [31:0] converted;
  logic [1:0] path;
  int gap_pct = 0;

  conversion_scoreboard sb = new();

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  piecewise_linear_table_convert_core uut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .command(command),
    .table_number(table_number), .point_index(point_index), .point_count(point_count),
    .point_raw(point_raw), .point_scaled(point_scaled), .sample(sample),
    .strobe(strobe), .converted(converted), .path(path)
  );

  always @(posedge clk)
    if (!rst && strobe) sb.check(converted, path);

  task automatic send(logic [1:0] cmd, logic [4:0] tn, logic [4:0] pi, logic [5:0] pc,
                      logic [31:0] praw, logic [31:0] pscl, logic [31:0] smp);
    if ($urandom_range(99) < gap_pct) begin
      @(negedge clk);
      start <= 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
    end else begin
      @(negedge clk);
    end
    command <= cmd;
    table_number <= tn;
    point_index <= pi;
    point_count <= pc;
    point_raw <= praw;
    point_scaled <= pscl;
    sample <= smp;
    start <= 1'b1;
    do @(posedge clk); while (busy);
    sb.note(cmd, tn, pi, pc, praw, pscl, smp);
  endtask

  task automatic load_point(int tn, int pi, logic [31:0] r, logic [31:0] s);
    send(CMD_WRITE, 5'(tn), 5'(pi), 6'($urandom), r, s, $urandom);
  endtask

  task automatic convert(int tn, logic [31:0] smp);
    int t;
    int g;
    // never let a convert read an entry that was never loaded
    if (tn >= 1 && tn <= NTAB) begin
      t = tn - 1;
      g = sb.first_gap(t);
      while (g >= 0) begin
        load_point(tn, g, $urandom, $urandom);
        g = sb.first_gap(t);
      end
    end
    send(CMD_CONVERT, 5'(tn), 5'($urandom), 6'($urandom), $urandom, $urandom, smp);
  endtask

  // one table: load breakpoints (mostly sorted), set its count, then convert a few samples
  task automatic table_session();
    int tn, n, k, j;
    int xs [$];
    longint lo, hi;
    logic [31:0] smp;
    tn = $urandom_range(1, NTAB);
    n = ($urandom_range(9) == 0) ? NPTS : $urandom_range(0, 6);
    xs = {};
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(3) == 0) xs.push_back(int'($urandom));
      else xs.push_back(int'($urandom_range(4000)) - 2000);
    end
    if ($urandom_range(7) != 0) xs.sort();
    for (int i = 0; i < n; i++) load_point(tn, i, xs[i], $urandom);
    k = ($urandom_range(11) == 0) ? $urandom_range(0, 63) : n;
    send(CMD_COUNT, 5'(tn), 5'($urandom), 6'(k), $urandom, $urandom, $urandom);
    repeat ($urandom_range(2, 8)) begin
      j = (n > 0) ? $urandom_range(n - 1) : 0;
      case ($urandom_range(4))
        0: smp = (n > 0) ? xs[j] : $urandom;
        1: begin
          if (n > 1 && j + 1 < n) begin
            lo = xs[j];
            hi = xs[j+1];
            smp = (hi > lo) ? 32'(lo + longint'($urandom) % (hi - lo)) : 32'(lo);
          end else smp = $urandom;
        end
        2: smp = $urandom;
        default: smp = 32'(int'($urandom_range(6000)) - 3000);
      endcase
      convert(($urandom_range(15) == 0) ? $urandom_range(0, 31) : tn, smp);
    end
  endtask

  task automatic noise_item();
    case ($urandom_range(3))
      0: send(CMD_UNUSED, 5'($urandom), 5'($urandom), 6'($urandom), $urandom, $urandom,
              $urandom);
      1: send(CMD_WRITE, 5'($urandom_range(17, 31)), 5'($urandom), 6'($urandom), $urandom,
              $urandom, $urandom);
      2: send(CMD_COUNT, 5'($urandom_range(0, 1) ? 0 : 17), 5'($urandom), 6'($urandom),
              $urandom, $urandom, $urandom);
      default: convert($urandom_range(0, 31), $urandom);
    endcase
  endtask

  initial begin
    int sent;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: extreme breakpoints, exact hits, interpolation, pass-through cases
    load_point(1, 0, 32'h8000_0000, 32'h7fff_ffff);
    load_point(1, 1, 32'h0000_0000, 32'h8000_0000);
    load_point(1, 2, 32'h7fff_ffff, 32'h7fff_ffff);
    send(CMD_COUNT, 5'd1, 5'd0, 6'd3, '0, '0, '0);
    convert(1, 32'h8000_0000);
    convert(1, 32'h0000_0000);
    convert(1, 32'h7fff_ffff);
    convert(1, 32'hc000_0001);
    convert(1, 32'h4000_0000);
    convert(0, 32'h1234_5678);
    convert(17, 32'hffff_ffff);
    convert(31, 32'h8000_0000);
    load_point(16, 31, 32'h0001_0000, 32'hffff_0000);
    load_point(0, 0, 32'h1, 32'h1);
    send(CMD_COUNT, 5'd16, 5'd0, 6'd1, '0, '0, '0);
    convert(16, 32'h0001_0000);
    send(CMD_COUNT, 5'd2, 5'd0, 6'd63, '0, '0, '0);
    send(CMD_UNUSED, 5'd1, 5'd31, 6'd32, '1, '1, '1);
    convert(2, 32'h0000_0000);
    convert(5, 32'h0000_0005);

    sent = 0;
    for (int ph = 0; ph < 4; ph++) begin
      gap_pct = (ph == 1) ? 82 : (ph == 3) ? 32 : 0;
      while (sent < (ph + 1) * 460) begin
        if ($urandom_range(9) < 8) table_session();
        else noise_item();
        sent += 10;
      end
    end
    @(negedge clk);
    start <= 1'b0;

    while (sb.pending_value.size() != 0) @(posedge clk);
    repeat (120) @(posedge clk);
    if (sb.errors == 0) $display("tb passed");
    else $display("tb failed");
    $finish;
  end

  initial begin
    #2000000;
    $display("tb failed");
    $finish;
  end
endmodule
